// ===== sv/hierarchical_timer_wheel_top_macros.svh =====
// Assertion helpers used by the timer wheel controller.
`ifndef HIERARCHICAL_TIMER_WHEEL_TOP_MACROS_SVH
`define HIERARCHICAL_TIMER_WHEEL_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define HTW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/htw_pkg.sv =====
package htw_pkg;

	// Default sizes of the wheel
	localparam int NUM_TIMERS_D = 64;
	localparam int ROOT_BITS_D  = 8;
	localparam int LEVEL_BITS_D = 6;

	// Results emitted per advance at most
	localparam int MAX_OUT = 64;

	// Action codes
	localparam logic [1:0] ACT_ARM = 2'd0;
	localparam logic [1:0] ACT_MOD = 2'd1;
	localparam logic [1:0] ACT_DEL = 2'd2;
	localparam logic [1:0] ACT_ADV = 2'd3;

	// Field write enables of the timer memory
	localparam int WE_EXP  = 0;
	localparam int WE_NEXT = 1;
	localparam int WE_PREV = 2;
	localparam int WE_SLOT = 3;

	// One result item
	typedef struct packed {
		logic       was_pending;
		logic       expired_valid;
		logic [5:0] expired_timer;
		logic [6:0] fired_count;
		logic       last;
	} res_t;

endpackage

// ===== sv/htw_bkt_mem.sv =====
module htw_bkt_mem #(
	parameter int DEPTH = 512,
	parameter int TW = 6
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic                     wr_ne,
	input  logic [TW-1:0]            wr_head,
	input  logic [TW-1:0]            wr_tail,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic                     rd_ne,
	output logic [TW-1:0]            rd_head,
	output logic [TW-1:0]            rd_tail
);
	localparam int EW = 1 + 2 * TW;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;
	logic [EW-1:0] wr_word;

	assign wr_word = {wr_ne, wr_head, wr_tail};

	// Write, then read with write-first bypass
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (wr_en && wr_addr == rd_addr) begin
			rd_q <= wr_word;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_ne   = rd_q[EW-1];
	assign rd_head = rd_q[2*TW-1:TW];
	assign rd_tail = rd_q[TW-1:0];
endmodule

// ===== sv/htw_tmr_mem.sv =====
module htw_tmr_mem #(
	parameter int DEPTH = 64,
	parameter int BW = 9
) (
	input  logic                     clk,
	input  logic [3:0]               wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [31:0]              wr_exp,
	input  logic [$clog2(DEPTH):0]   wr_next,
	input  logic [$clog2(DEPTH):0]   wr_prev,
	input  logic [BW-1:0]            wr_slot,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [31:0]              rd_exp,
	output logic [$clog2(DEPTH):0]   rd_next,
	output logic [$clog2(DEPTH):0]   rd_prev,
	output logic [BW-1:0]            rd_slot
);
	import htw_pkg::*;
	localparam int PW = $clog2(DEPTH) + 1;

	logic [31:0]   exp_mem  [DEPTH];
	logic [PW-1:0] next_mem [DEPTH];
	logic [PW-1:0] prev_mem [DEPTH];
	logic [BW-1:0] slot_mem [DEPTH];
	logic          hit;

	assign hit = (wr_addr == rd_addr);

	// Field-wise write, registered read with bypass
	always_ff @(posedge clk) begin
		if (wr_en[WE_EXP])  exp_mem[wr_addr]  <= wr_exp;
		if (wr_en[WE_NEXT]) next_mem[wr_addr] <= wr_next;
		if (wr_en[WE_PREV]) prev_mem[wr_addr] <= wr_prev;
		if (wr_en[WE_SLOT]) slot_mem[wr_addr] <= wr_slot;
		rd_exp  <= (hit && wr_en[WE_EXP])  ? wr_exp  : exp_mem[rd_addr];
		rd_next <= (hit && wr_en[WE_NEXT]) ? wr_next : next_mem[rd_addr];
		rd_prev <= (hit && wr_en[WE_PREV]) ? wr_prev : prev_mem[rd_addr];
		rd_slot <= (hit && wr_en[WE_SLOT]) ? wr_slot : slot_mem[rd_addr];
	end
endmodule

// ===== sv/htw_ctrl.sv =====
`include "hierarchical_timer_wheel_top_macros.svh"

module htw_ctrl #(
	parameter int NUM_TIMERS = 64,
	parameter int ROOT_BITS = 8,
	parameter int LEVEL_BITS = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_action,
	input  logic [5:0]    in_id,
	input  logic [31:0]   in_tv,
	input  logic          cfg_valid,
	input  logic [31:0]   cfg_data,
	output logic          res_valid,
	input  logic          res_ready,
	output htw_pkg::res_t res
);
	import htw_pkg::*;

	localparam int TW = $clog2(NUM_TIMERS);
	localparam int PW = TW + 1;
	localparam int ROOT = 1 << ROOT_BITS;
	localparam int LVL = 1 << LEVEL_BITS;
	localparam int NB = ROOT + 4 * LVL;
	localparam int BW = $clog2(NB);
	localparam int SH1 = ROOT_BITS;
	localparam int SH2 = ROOT_BITS + LEVEL_BITS;
	localparam int SH3 = ROOT_BITS + 2 * LEVEL_BITS;
	localparam int SH4 = ROOT_BITS + 3 * LEVEL_BITS;
	localparam int SPAN = ROOT_BITS + 4 * LEVEL_BITS;
	localparam logic [63:0] LMASK = 64'(LVL - 1);
	localparam logic [63:0] MAXV = (64'd1 << SPAN) - 64'd1;

	localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_A0 = 5'd2, S_A1 = 5'd3,
		S_A2 = 5'd4, S_A3 = 5'd5, S_RES = 5'd6, S_TICK = 5'd7, S_CASC = 5'd8,
		S_CASC2 = 5'd9, S_DR0 = 5'd10, S_DR1 = 5'd11, S_DR2 = 5'd12, S_PUSH = 5'd13,
		S_FIN = 5'd14, S_P0 = 5'd15, S_P1 = 5'd16, S_P2 = 5'd17, S_P3 = 5'd18,
		S_P4 = 5'd19, S_L0 = 5'd20, S_L1 = 5'd21, S_L2 = 5'd22, S_U0 = 5'd23,
		S_U1 = 5'd24, S_U2 = 5'd25, S_U3 = 5'd26;

	// Bucket index of a timer by its distance to expiry
	function automatic logic [BW-1:0] place_f(input logic [31:0] e, input logic [31:0] c);
		logic [31:0] d;
		logic [63:0] dd;
		logic [63:0] ee;
		logic [BW-1:0] b;
		d = e - c;
		dd = {32'b0, d};
		ee = {32'b0, e};
		if (d[31]) begin
			b = BW'(c[ROOT_BITS-1:0]);
		end else if (dd < (64'd1 << SH1)) begin
			b = BW'(e[ROOT_BITS-1:0]);
		end else if (dd < (64'd1 << SH2)) begin
			b = BW'(64'(ROOT) + ((ee >> SH1) & LMASK));
		end else if (dd < (64'd1 << SH3)) begin
			b = BW'(64'(ROOT + LVL) + ((ee >> SH2) & LMASK));
		end else if (dd < (64'd1 << SH4)) begin
			b = BW'(64'(ROOT + 2 * LVL) + ((ee >> SH3) & LMASK));
		end else begin
			if (dd > MAXV) begin
				ee = ({32'b0, c} + MAXV) & 64'hFFFF_FFFF;
			end
			b = BW'(64'(ROOT + 3 * LVL) + ((ee >> SH4) & LMASK));
		end
		return b;
	endfunction

	// Index of the current tick within an upper level
	function automatic logic [LEVEL_BITS-1:0] li_f(input logic [1:0] lvl,
			input logic [31:0] c);
		logic [63:0] cc;
		logic [63:0] r;
		cc = {32'b0, c};
		case (lvl)
			2'd0: r = cc >> SH1;
			2'd1: r = cc >> SH2;
			2'd2: r = cc >> SH3;
			default: r = cc >> SH4;
		endcase
		return LEVEL_BITS'(r & LMASK);
	endfunction

	logic [4:0]            state_q, ret_q;
	logic [1:0]            act_q;
	logic [31:0]           tv_q, cur_q, e_q;
	logic [TW-1:0]         t_q, l_tail_q, hold_id_q;
	logic [BW-1:0]         b_q, clr_q, u_slot_q;
	logic [PW-1:0]         nx_q, u_p_q, u_n_q;
	logic                  wp_q, hold_v_q;
	logic [1:0]            lvl_q;
	logic [LEVEL_BITS-1:0] li_q;
	logic [ROOT_BITS-1:0]  idx_q;
	logic [TW:0]           rc_q, n_q;
	logic [6:0]            emit_q;
	logic [NUM_TIMERS-1:0] armed_q;

	// Memory ports
	logic          bk_we, bk_wne, bk_rne;
	logic [BW-1:0] bk_waddr, bk_raddr;
	logic [TW-1:0] bk_whead, bk_wtail, bk_rhead, bk_rtail;
	logic [3:0]    tm_we;
	logic [TW-1:0] tm_waddr, tm_raddr;
	logic [31:0]   tm_wexp, tm_rexp;
	logic [PW-1:0] tm_wnext, tm_wprev, tm_rnext, tm_rprev;
	logic [BW-1:0] tm_wslot, tm_rslot;

	logic [31:0]           diff;
	logic                  tick_ok;
	logic [ROOT_BITS-1:0]  idx_now;
	logic [BW-1:0]         place_b, casc_b;
	logic [LEVEL_BITS-1:0] li;
	logic [32:0]           steps, remain;
	logic [6:0]            n_sat;
	logic                  id_ok;

	htw_bkt_mem #(.DEPTH(NB), .TW(TW)) u_bkt (
		.clk(clk), .wr_en(bk_we), .wr_addr(bk_waddr), .wr_ne(bk_wne),
		.wr_head(bk_whead), .wr_tail(bk_wtail), .rd_addr(bk_raddr),
		.rd_ne(bk_rne), .rd_head(bk_rhead), .rd_tail(bk_rtail)
	);

	htw_tmr_mem #(.DEPTH(NUM_TIMERS), .BW(BW)) u_tmr (
		.clk(clk), .wr_en(tm_we), .wr_addr(tm_waddr), .wr_exp(tm_wexp),
		.wr_next(tm_wnext), .wr_prev(tm_wprev), .wr_slot(tm_wslot),
		.rd_addr(tm_raddr), .rd_exp(tm_rexp), .rd_next(tm_rnext),
		.rd_prev(tm_rprev), .rd_slot(tm_rslot)
	);

	// Tick walk arithmetic
	assign diff    = tv_q - cur_q;
	assign tick_ok = !diff[31];
	assign idx_now = cur_q[ROOT_BITS-1:0];
	assign place_b = place_f(e_q, cur_q);
	assign li      = li_f(lvl_q, cur_q);
	assign casc_b  = BW'(ROOT + 32'(lvl_q) * LVL + 32'(li));
	assign steps   = 33'(ROOT) - 33'(idx_now);
	assign remain  = {1'b0, diff} + 33'd1;
	assign n_sat   = (32'(n_q) > 127) ? 7'd127 : 7'(n_q);
	assign id_ok   = 32'(in_id) < NUM_TIMERS;
	assign in_ready = (state_q == S_IDLE);

	// Drive memory ports by state
	always_comb begin
		bk_we = 1'b0; bk_waddr = b_q; bk_wne = 1'b0;
		bk_whead = t_q; bk_wtail = t_q; bk_raddr = b_q;
		tm_we = 4'b0; tm_waddr = t_q; tm_wexp = tv_q;
		tm_wnext = '0; tm_wprev = '0; tm_wslot = b_q; tm_raddr = t_q;
		case (state_q)
			S_CLR: begin
				bk_we = 1'b1; bk_waddr = clr_q;
			end
			S_A2: begin
				tm_we[WE_EXP] = 1'b1;
			end
			S_L0: begin
				bk_raddr = place_b;
			end
			S_L1: begin
				tm_we[WE_NEXT] = 1'b1; tm_we[WE_PREV] = 1'b1; tm_we[WE_SLOT] = 1'b1;
				tm_wprev = bk_rne ? {1'b1, bk_rtail} : '0;
				bk_we = 1'b1; bk_wne = 1'b1;
				bk_whead = bk_rne ? bk_rhead : t_q;
			end
			S_L2: begin
				tm_we[WE_NEXT] = 1'b1; tm_waddr = l_tail_q; tm_wnext = {1'b1, t_q};
			end
			S_U1: begin
				bk_raddr = tm_rslot;
			end
			S_U2: begin
				bk_we = 1'b1; bk_waddr = u_slot_q;
				bk_wne = u_p_q[TW] | u_n_q[TW];
				bk_whead = u_p_q[TW] ? bk_rhead : u_n_q[TW-1:0];
				bk_wtail = u_n_q[TW] ? bk_rtail : u_p_q[TW-1:0];
				tm_we[WE_NEXT] = u_p_q[TW]; tm_waddr = u_p_q[TW-1:0]; tm_wnext = u_n_q;
			end
			S_U3: begin
				tm_we[WE_PREV] = 1'b1; tm_waddr = u_n_q[TW-1:0]; tm_wprev = u_p_q;
			end
			S_DR0: begin
				bk_raddr = BW'(idx_q);
			end
			S_P1: begin
				bk_we = bk_rne;
			end
			default: begin
			end
		endcase
	end

	// Result toward the output register
	always_comb begin
		res = '0;
		res_valid = 1'b0;
		case (state_q)
			S_RES: begin
				res_valid = 1'b1; res.was_pending = wp_q; res.last = 1'b1;
			end
			S_PUSH: begin
				res_valid = 1'b1; res.expired_valid = 1'b1; res.expired_timer = 6'(hold_id_q);
			end
			S_FIN: begin
				res_valid = 1'b1; res.expired_valid = hold_v_q;
				res.expired_timer = hold_v_q ? 6'(hold_id_q) : 6'd0;
				res.fired_count = n_sat; res.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q <= S_IDLE;
			clr_q <= '0;
			cur_q <= '0;
			rc_q <= '0;
			armed_q <= '0;
			hold_v_q <= 1'b0;
			emit_q <= '0;
			n_q <= '0;
		end else begin
			if (cfg_valid) begin
				cur_q <= cfg_data;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NB - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						act_q <= in_action;
						tv_q <= in_tv;
						t_q <= TW'(in_id);
						wp_q <= id_ok ? armed_q[TW'(in_id)] : 1'b0;
						if (in_action == ACT_ADV) begin
							n_q <= '0; emit_q <= '0; hold_v_q <= 1'b0;
							state_q <= S_TICK;
						end else begin
							state_q <= id_ok ? S_A0 : S_RES;
						end
					end
				end
				S_A0: state_q <= S_A1;
				S_A1: begin
					if (act_q == ACT_DEL) begin
						ret_q <= S_A3;
						state_q <= wp_q ? S_U0 : S_RES;
					end else if (act_q == ACT_ARM && wp_q && tm_rexp == tv_q) begin
						state_q <= S_RES;
					end else if (wp_q) begin
						ret_q <= S_A3; state_q <= S_U0;
					end else begin
						state_q <= (act_q == ACT_ARM) ? S_A2 : S_RES;
					end
				end
				S_A3: begin
					if (act_q == ACT_DEL) begin
						armed_q[t_q] <= 1'b0; state_q <= S_RES;
					end else begin
						state_q <= S_A2;
					end
				end
				S_A2: begin
					armed_q[t_q] <= 1'b1; e_q <= tv_q; ret_q <= S_RES; state_q <= S_L0;
				end
				S_RES: if (res_ready) state_q <= S_IDLE;
				S_TICK: begin
					if (!tick_ok) begin
						state_q <= S_FIN;
					end else if (idx_now == '0) begin
						lvl_q <= 2'd0; state_q <= S_CASC;
					end else if (rc_q == '0) begin
						if (steps >= remain) begin
							cur_q <= tv_q + 32'd1; state_q <= S_FIN;
						end else begin
							cur_q <= cur_q + 32'(steps);
						end
					end else begin
						idx_q <= idx_now; cur_q <= cur_q + 32'd1; state_q <= S_DR0;
					end
				end
				S_CASC: begin
					b_q <= casc_b; li_q <= li; state_q <= S_P0;
				end
				S_CASC2: begin
					if (li_q != '0 || lvl_q == 2'd3) begin
						idx_q <= idx_now; cur_q <= cur_q + 32'd1; state_q <= S_DR0;
					end else begin
						lvl_q <= lvl_q + 2'd1; state_q <= S_CASC;
					end
				end
				S_P0: state_q <= S_P1;
				S_P1: begin
					t_q <= bk_rhead;
					state_q <= bk_rne ? S_P2 : S_CASC2;
				end
				S_P2: state_q <= S_P3;
				S_P3: begin
					nx_q <= tm_rnext; e_q <= tm_rexp; ret_q <= S_P4; state_q <= S_L0;
				end
				S_P4: begin
					t_q <= nx_q[TW-1:0];
					state_q <= nx_q[TW] ? S_P2 : S_CASC2;
				end
				S_L0: begin
					b_q <= place_b; state_q <= S_L1;
				end
				S_L1: begin
					l_tail_q <= bk_rtail;
					if (32'(b_q) < ROOT) rc_q <= rc_q + 1'b1;
					state_q <= bk_rne ? S_L2 : ret_q;
				end
				S_L2: state_q <= ret_q;
				S_U0: state_q <= S_U1;
				S_U1: begin
					u_p_q <= tm_rprev; u_n_q <= tm_rnext; u_slot_q <= tm_rslot;
					state_q <= S_U2;
				end
				S_U2: begin
					if (32'(u_slot_q) < ROOT && rc_q != '0) rc_q <= rc_q - 1'b1;
					state_q <= u_n_q[TW] ? S_U3 : ret_q;
				end
				S_U3: state_q <= ret_q;
				S_DR0: state_q <= S_DR1;
				S_DR1: begin
					t_q <= bk_rhead; ret_q <= S_DR2;
					state_q <= bk_rne ? S_U0 : S_TICK;
				end
				S_DR2: begin
					armed_q[t_q] <= 1'b0;
					n_q <= n_q + 1'b1;
					if (32'(emit_q) < MAX_OUT && hold_v_q) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_DR0;
						if (32'(emit_q) < MAX_OUT) begin
							hold_v_q <= 1'b1; hold_id_q <= t_q; emit_q <= emit_q + 7'd1;
						end
					end
				end
				S_PUSH: begin
					if (res_ready) begin
						hold_id_q <= t_q; emit_q <= emit_q + 7'd1; state_q <= S_DR0;
					end
				end
				S_FIN: if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HTW_ASSERT_IMP(a_rc_bound, 1'b1, 32'($countones(armed_q)) >= 32'(rc_q), "root count exceeds armed timers")
	`HTW_ASSERT_IMP(a_emit_bound, 1'b1, 32'(emit_q) <= MAX_OUT, "emit count overflow")
	`HTW_ASSERT_NXT(a_take, in_valid && in_ready, state_q != S_IDLE, "item taken but sequencer idle")
	`HTW_ASSERT_IMP(a_push_hold, state_q == S_PUSH, hold_v_q, "push without held timer")
endmodule

// ===== sv/hierarchical_timer_wheel_top.sv =====
// Channel   Dir  Width  Contents
// s_*       in   40+2   tdata: timer_id, time_value; tuser: action
// m_*       out  16+1+1 tdata: was_pending, expired_timer, fired_count; tuser, tlast
// cfg_*     in   32     start_time, loads the current tick
//
// Arm, modify and delete run as a few read-modify-writes of the bucket and timer
// memories, one access of each per cycle. Advance walks the ticks, visits the upper
// buckets on a root wrap, cascades their timers and fires the expired ones; a run
// of root buckets is skipped at once while no timer sits in the root level.
// After reset a clearing pass over all ROOT + 4*LVL buckets (512 by default) runs
// before the first item is taken; configuration writes are taken throughout.
// A stalled output holds the sequencer; one result waits in the output register.
module hierarchical_timer_wheel_top #(
	parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS_D,
	parameter int ROOT_BITS = htw_pkg::ROOT_BITS_D,
	parameter int LEVEL_BITS = htw_pkg::LEVEL_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // timer_id[5:0], time_value[37:6], zero pad
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // was_pending[0], expired_timer[6:1], fired_count[13:7]
	output logic        m_tuser,   // expired_valid[0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import htw_pkg::*;

	res_t res;
	logic res_valid, res_ready;
	res_t out_q;
	logic out_v_q;

	htw_ctrl #(
		.NUM_TIMERS(NUM_TIMERS), .ROOT_BITS(ROOT_BITS), .LEVEL_BITS(LEVEL_BITS)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_action(s_tuser), .in_id(s_tdata[5:0]), .in_tv(s_tdata[37:6]),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	assign cfg_ready = 1'b1;
	assign res_ready = !out_v_q || m_tready;

	// Hold one result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b0, out_q.fired_count, out_q.expired_timer, out_q.was_pending};
	assign m_tuser  = out_q.expired_valid;
	assign m_tlast  = out_q.last;
endmodule
